// ----- hdl/differential_drive_mixer_failsafe_defines.svh -----
// assertion macros used by ddm_back.sv
`ifndef DIFFERENTIAL_DRIVE_MIXER_FAILSAFE_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_FAILSAFE_DEFINES_SVH

`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define DDM_ASSERT_NOW(NAME, CLK, RSTN, COND, CONSEQ) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (COND) |-> (CONSEQ)) \
        else $error("ddm assertion failed");
// condition implies consequence in the next cycle
`define DDM_ASSERT_NEXT(NAME, CLK, RSTN, COND, CONSEQ) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (COND) |=> (CONSEQ)) \
        else $error("ddm assertion failed");
`else
`define DDM_ASSERT_NOW(NAME, CLK, RSTN, COND, CONSEQ)
`define DDM_ASSERT_NEXT(NAME, CLK, RSTN, COND, CONSEQ)
`endif

`endif

// ----- hdl/ddm_pkg.sv -----
package ddm_pkg;

    // fixed point format
    localparam int FRAC_BITS = 14;
    localparam int DUTY_BITS = 8;
    localparam int Q_W       = 16;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int SPD_W     = 15;
    localparam int DZ_W      = 15;
    localparam int BASE_W    = (MAG_W > SPD_W) ? MAG_W : SPD_W;
    localparam int TMO_W     = 16;
    localparam int IDLE_W    = 17;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // command queue
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [MAG_W-1:0]        Q_ONE    = MAG_W'(1) << FRAC_BITS;
    localparam logic signed [Q_W-1:0]   Q_POS    = Q_W'(1) << FRAC_BITS;
    localparam logic signed [Q_W-1:0]   Q_NEG    = -Q_POS;
    localparam logic [DUTY_BITS-1:0]    DUTY_MAX = '1;
    localparam logic [IDLE_W-1:0]       IDLE_MAX = '1;

    typedef enum logic [1:0] {
        ACT_DRIVE = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADZONE     = 3'd0,
        REG_SPIN_SPEED   = 3'd1,
        REG_TIMEOUT      = 3'd2,
        REG_BLINK_HALF   = 3'd3,
        REG_INV_STEERING = 3'd4,
        REG_INV_LEFT     = 3'd5,
        REG_INV_RIGHT    = 3'd6
    } reg_idx_t;

    // bit 0 drives bridge input a, bit 1 input b
    typedef enum logic [1:0] {
        DIR_OFF = 2'b00,
        DIR_FWD = 2'b01,
        DIR_REV = 2'b10
    } dir_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_MUL  = 2'd1,
        B_OUT  = 2'd2
    } back_state_t;

    typedef struct packed {
        logic [DZ_W-1:0]  deadzone;
        logic [SPD_W-1:0] spin_speed;
        logic [TMO_W-1:0] timeout_ticks;
        logic [TMO_W-1:0] blink_half_ticks;
        logic             negate_steer;
        logic             invert_left;
        logic             invert_right;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        deadzone:         DZ_W'(819),
        spin_speed:       SPD_W'(11469),
        timeout_ticks:    TMO_W'(600),
        blink_half_ticks: TMO_W'(500),
        negate_steer:     1'b1,
        invert_left:      1'b0,
        invert_right:     1'b0
    };

    // classified command handed from front to back
    typedef struct packed {
        act_t              action;
        logic [BASE_W-1:0] base_mag;
        logic              base_neg;
        logic [MAG_W-1:0]  factor;
        logic              scale_left;
    } cmd_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] left_duty;
        dir_t                 left_dir;
        logic [DUTY_BITS-1:0] right_duty;
        dir_t                 right_dir;
        logic                 led_on;
        logic                 failsafe;
    } res_t;

endpackage

// ----- hdl/ddm_front.sv -----
module ddm_front (
    input  ddm_pkg::cfg_t                    cfg,
    input  logic [1:0]                       action,
    input  logic signed [ddm_pkg::Q_W-1:0]   steer,
    input  logic signed [ddm_pkg::Q_W-1:0]   throttle,
    output ddm_pkg::cmd_t                    cmd
);

    logic signed [ddm_pkg::Q_W-1:0] s_sat;
    logic signed [ddm_pkg::Q_W-1:0] t_sat;
    logic signed [ddm_pkg::Q_W-1:0] s_inv;
    logic signed [ddm_pkg::Q_W-1:0] s_abs;
    logic signed [ddm_pkg::Q_W-1:0] t_abs;
    logic [ddm_pkg::MAG_W-1:0]      s_mag;
    logic [ddm_pkg::MAG_W-1:0]      t_mag;
    logic                           s_nz;
    logic                           t_nz;

    function automatic logic signed [ddm_pkg::Q_W-1:0] sat_one(
        input logic signed [ddm_pkg::Q_W-1:0] v
    );
        if (v > ddm_pkg::Q_POS)
        begin
            return ddm_pkg::Q_POS;
        end
        else if (v < ddm_pkg::Q_NEG)
        begin
            return ddm_pkg::Q_NEG;
        end
        return v;
    endfunction

    // clamp, optional steer inversion, magnitudes
    always_comb
    begin
        s_sat = sat_one(steer);
        t_sat = sat_one(throttle);
        s_inv = cfg.negate_steer ? -s_sat : s_sat;
        s_abs = s_inv[ddm_pkg::Q_W-1] ? -s_inv : s_inv;
        t_abs = t_sat[ddm_pkg::Q_W-1] ? -t_sat : t_sat;
        s_mag = s_abs[ddm_pkg::MAG_W-1:0];
        t_mag = t_abs[ddm_pkg::MAG_W-1:0];
    end

    // deadzone: small magnitudes count as zero
    assign s_nz = (s_mag != '0) && !(ddm_pkg::DZ_W'(s_mag) < cfg.deadzone);
    assign t_nz = (t_mag != '0) && !(ddm_pkg::DZ_W'(t_mag) < cfg.deadzone);

    // pick base speed and the inner wheel factor
    always_comb
    begin
        cmd.action = ddm_pkg::act_t'(action);
        if (t_nz)
        begin
            cmd.base_mag = ddm_pkg::BASE_W'(t_mag);
            cmd.base_neg = t_sat[ddm_pkg::Q_W-1];
        end
        else if (s_nz)
        begin
            cmd.base_mag = ddm_pkg::BASE_W'(cfg.spin_speed);
            cmd.base_neg = 1'b0;
        end
        else
        begin
            cmd.base_mag = '0;
            cmd.base_neg = 1'b0;
        end
        cmd.factor     = s_nz ? (ddm_pkg::Q_ONE - s_mag) : ddm_pkg::Q_ONE;
        cmd.scale_left = s_nz && s_inv[ddm_pkg::Q_W-1];
    end

endmodule

// ----- hdl/ddm_cmdq.sv -----
module ddm_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ddm_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output ddm_pkg::cmd_t dout,
    output logic          empty
);

    ddm_pkg::cmd_t                  mem_reg [ddm_pkg::CMDQ_DEPTH];
    logic [ddm_pkg::CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [ddm_pkg::CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [ddm_pkg::CMDQ_CNT_W-1:0] count_reg;
    logic [ddm_pkg::CMDQ_PTR_W-1:0] wr_ptr_next;
    logic [ddm_pkg::CMDQ_PTR_W-1:0] rd_ptr_next;
    logic [ddm_pkg::CMDQ_CNT_W-1:0] count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == ddm_pkg::CMDQ_CNT_W'(ddm_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointer wrap and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ddm_pkg::CMDQ_PTR_W'(ddm_pkg::CMDQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ddm_pkg::CMDQ_PTR_W'(ddm_pkg::CMDQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hdl/ddm_back.sv -----
`include "differential_drive_mixer_failsafe_defines.svh"

module ddm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  ddm_pkg::cfg_t cfg,
    input  ddm_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    output ddm_pkg::res_t res,
    output logic          res_valid,
    input  logic          res_pop
);

    localparam int PROD_W = ddm_pkg::BASE_W + ddm_pkg::MAG_W;
    localparam int DFUL_W = ddm_pkg::MAG_W + ddm_pkg::DUTY_BITS;

    ddm_pkg::back_state_t state_reg;
    ddm_pkg::back_state_t state_next;
    logic                 commit;

    ddm_pkg::cmd_t                cmd_reg;
    logic [ddm_pkg::BASE_W-1:0]   prod_reg;
    logic [PROD_W-1:0]            prod_full;

    logic [ddm_pkg::IDLE_W-1:0]    idle_reg;
    logic [ddm_pkg::IDLE_W-1:0]    idle_next;
    logic [ddm_pkg::TMO_W-1:0]     blink_reg;
    logic [ddm_pkg::TMO_W-1:0]     blink_next;
    logic                          phase_reg;
    logic                          phase_next;
    logic [ddm_pkg::DUTY_BITS-1:0] l_duty_reg;
    logic [ddm_pkg::DUTY_BITS-1:0] l_duty_next;
    ddm_pkg::dir_t                 l_dir_reg;
    ddm_pkg::dir_t                 l_dir_next;
    logic [ddm_pkg::DUTY_BITS-1:0] r_duty_reg;
    logic [ddm_pkg::DUTY_BITS-1:0] r_duty_next;
    ddm_pkg::dir_t                 r_dir_reg;
    ddm_pkg::dir_t                 r_dir_next;

    logic [ddm_pkg::BASE_W-1:0]    l_mag;
    logic [ddm_pkg::BASE_W-1:0]    r_mag;
    logic [ddm_pkg::MAG_W-1:0]     l_sat;
    logic [ddm_pkg::MAG_W-1:0]     r_sat;
    logic [DFUL_W-1:0]             l_dful;
    logic [DFUL_W-1:0]             r_dful;
    logic [ddm_pkg::DUTY_BITS-1:0] l_duty;
    logic [ddm_pkg::DUTY_BITS-1:0] r_duty;
    logic                          l_fwd;
    logic                          r_fwd;
    logic [ddm_pkg::TMO_W-1:0]     half;
    logic [ddm_pkg::TMO_W:0]       blink_inc;
    logic                          fs;

    ddm_pkg::res_t res_reg;
    ddm_pkg::res_t res_next;
    logic          res_valid_reg;

    // sequencer: fetch, multiply, commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddm_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ddm_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = ddm_pkg::B_MUL;
                end
            end
            ddm_pkg::B_MUL:
            begin
                state_next = ddm_pkg::B_OUT;
            end
            ddm_pkg::B_OUT:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    commit     = 1'b1;
                    state_next = ddm_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ddm_pkg::B_IDLE;
            end
        endcase
    end

    // inner wheel product, truncated magnitude
    assign prod_full = PROD_W'(cmd_reg.base_mag) * PROD_W'(cmd_reg.factor);

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == ddm_pkg::B_MUL)
        begin
            prod_reg <= ddm_pkg::BASE_W'(prod_full >> ddm_pkg::FRAC_BITS);
        end
    end

    // wheel saturation, duty and direction
    always_comb
    begin
        l_mag  = cmd_reg.scale_left ? prod_reg : cmd_reg.base_mag;
        r_mag  = cmd_reg.scale_left ? cmd_reg.base_mag : prod_reg;
        l_sat  = (l_mag > ddm_pkg::BASE_W'(ddm_pkg::Q_ONE)) ? ddm_pkg::Q_ONE
                                                            : ddm_pkg::MAG_W'(l_mag);
        r_sat  = (r_mag > ddm_pkg::BASE_W'(ddm_pkg::Q_ONE)) ? ddm_pkg::Q_ONE
                                                            : ddm_pkg::MAG_W'(r_mag);
        l_dful = DFUL_W'(l_sat) * DFUL_W'(ddm_pkg::DUTY_MAX);
        r_dful = DFUL_W'(r_sat) * DFUL_W'(ddm_pkg::DUTY_MAX);
        l_duty = ddm_pkg::DUTY_BITS'(l_dful >> ddm_pkg::FRAC_BITS);
        r_duty = ddm_pkg::DUTY_BITS'(r_dful >> ddm_pkg::FRAC_BITS);
        l_fwd  = !cmd_reg.base_neg ^ cfg.invert_left;
        r_fwd  = !cmd_reg.base_neg ^ cfg.invert_right;
    end

    // state update for one item
    always_comb
    begin
        idle_next   = idle_reg;
        blink_next  = blink_reg;
        phase_next  = phase_reg;
        l_duty_next = l_duty_reg;
        l_dir_next  = l_dir_reg;
        r_duty_next = r_duty_reg;
        r_dir_next  = r_dir_reg;
        half        = (cfg.blink_half_ticks == '0) ? ddm_pkg::TMO_W'(1)
                                                   : cfg.blink_half_ticks;
        blink_inc   = {1'b0, blink_reg} + 1'b1;
        unique case (cmd_reg.action)
            ddm_pkg::ACT_DRIVE:
            begin
                l_duty_next = l_duty;
                r_duty_next = r_duty;
                l_dir_next  = (l_duty == '0) ? ddm_pkg::DIR_OFF
                              : (l_fwd ? ddm_pkg::DIR_FWD : ddm_pkg::DIR_REV);
                r_dir_next  = (r_duty == '0) ? ddm_pkg::DIR_OFF
                              : (r_fwd ? ddm_pkg::DIR_FWD : ddm_pkg::DIR_REV);
                idle_next   = '0;
                blink_next  = '0;
                phase_next  = 1'b0;
            end
            ddm_pkg::ACT_STOP:
            begin
                l_duty_next = '0;
                r_duty_next = '0;
                l_dir_next  = ddm_pkg::DIR_OFF;
                r_dir_next  = ddm_pkg::DIR_OFF;
                idle_next   = '0;
                blink_next  = '0;
                phase_next  = 1'b0;
            end
            ddm_pkg::ACT_TICK:
            begin
                if (idle_reg != ddm_pkg::IDLE_MAX)
                begin
                    idle_next = idle_reg + 1'b1;
                end
                if (idle_next > ddm_pkg::IDLE_W'(cfg.timeout_ticks))
                begin
                    l_duty_next = '0;
                    r_duty_next = '0;
                    l_dir_next  = ddm_pkg::DIR_OFF;
                    r_dir_next  = ddm_pkg::DIR_OFF;
                    if (blink_inc >= {1'b0, half})
                    begin
                        blink_next = '0;
                        phase_next = !phase_reg;
                    end
                    else
                    begin
                        blink_next = blink_inc[ddm_pkg::TMO_W-1:0];
                    end
                end
                else
                begin
                    blink_next = '0;
                    phase_next = 1'b0;
                end
            end
            ddm_pkg::ACT_NONE:
            begin
            end
            default:
            begin
            end
        endcase
        fs                  = idle_next > ddm_pkg::IDLE_W'(cfg.timeout_ticks);
        res_next.left_duty  = l_duty_next;
        res_next.left_dir   = l_dir_next;
        res_next.right_duty = r_duty_next;
        res_next.right_dir  = r_dir_next;
        res_next.failsafe   = fs;
        res_next.led_on     = !fs || !phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg      <= '0;
            blink_reg     <= '0;
            phase_reg     <= 1'b0;
            l_duty_reg    <= '0;
            l_dir_reg     <= ddm_pkg::DIR_OFF;
            r_duty_reg    <= '0;
            r_dir_reg     <= ddm_pkg::DIR_OFF;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                idle_reg   <= idle_next;
                blink_reg  <= blink_next;
                phase_reg  <= phase_next;
                l_duty_reg <= l_duty_next;
                l_dir_reg  <= l_dir_next;
                r_duty_reg <= r_duty_next;
                r_dir_reg  <= r_dir_next;
            end
            if (commit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result holding register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    `DDM_ASSERT_NEXT(a_fs_motors_off, clk, rst_n, commit && fs && cmd_reg.action == ddm_pkg::ACT_TICK, res_reg.left_duty == '0 && res_reg.right_duty == '0)
    `DDM_ASSERT_NOW(a_zero_duty_no_dir, clk, rst_n, res_valid_reg, (res_reg.left_duty != '0 || res_reg.left_dir == ddm_pkg::DIR_OFF) && (res_reg.right_duty != '0 || res_reg.right_dir == ddm_pkg::DIR_OFF))
    `DDM_ASSERT_NOW(a_led_outside_fs, clk, rst_n, res_valid_reg && !res_reg.failsafe, res_reg.led_on)
    `DDM_ASSERT_NEXT(a_mul_then_out, clk, rst_n, state_reg == ddm_pkg::B_MUL, state_reg == ddm_pkg::B_OUT)
    `DDM_ASSERT_NEXT(a_pop_starts_mul, clk, rst_n, cmd_pop, state_reg == ddm_pkg::B_MUL)

endmodule

// ----- hdl/differential_drive_mixer_failsafe.sv -----
// path: an accepted item passes the command queue, then cmd_reg (fetch), prod_reg
// (multiply) and res_reg (commit) before it shows on the outputs; commit waits while
// the previous result is unpopped, and the sequencer takes no new item until it commits
// a two-entry command queue takes items while the result register waits to be popped
// reset: rst_n low clears the command queue, counters and held motor state at once and
// loads the registers with their default values
module differential_drive_mixer_failsafe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          action,
    input  logic signed [ddm_pkg::Q_W-1:0]      steer,
    input  logic signed [ddm_pkg::Q_W-1:0]      throttle,
    output logic                                empty,
    input  logic                                pop,
    output logic [ddm_pkg::DUTY_BITS-1:0]       left_duty,
    output logic                                left_in_a,
    output logic                                left_in_b,
    output logic [ddm_pkg::DUTY_BITS-1:0]       right_duty,
    output logic                                right_in_a,
    output logic                                right_in_b,
    output logic                                led_on,
    output logic                                failsafe_active,
    input  logic                                cfg_wr_en,
    input  logic [ddm_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [ddm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    ddm_pkg::cfg_t cfg_reg;
    ddm_pkg::cmd_t front_cmd;
    ddm_pkg::cmd_t q_cmd;
    ddm_pkg::res_t res;
    logic          q_empty;
    logic          q_pop;
    logic          res_valid;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ddm_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (ddm_pkg::reg_idx_t'(cfg_addr))
                ddm_pkg::REG_DEADZONE:
                    cfg_reg.deadzone <= cfg_wdata[ddm_pkg::DZ_W-1:0];
                ddm_pkg::REG_SPIN_SPEED:
                    cfg_reg.spin_speed <= cfg_wdata[ddm_pkg::SPD_W-1:0];
                ddm_pkg::REG_TIMEOUT:
                    cfg_reg.timeout_ticks <= cfg_wdata[ddm_pkg::TMO_W-1:0];
                ddm_pkg::REG_BLINK_HALF:
                    cfg_reg.blink_half_ticks <= cfg_wdata[ddm_pkg::TMO_W-1:0];
                ddm_pkg::REG_INV_STEERING:
                    cfg_reg.negate_steer <= cfg_wdata[0];
                ddm_pkg::REG_INV_LEFT:
                    cfg_reg.invert_left <= cfg_wdata[0];
                ddm_pkg::REG_INV_RIGHT:
                    cfg_reg.invert_right <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // classify incoming item
    ddm_front u_front (
        .cfg      (cfg_reg),
        .action   (action),
        .steer    (steer),
        .throttle (throttle),
        .cmd      (front_cmd)
    );

    // decoupling queue
    ddm_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_cmd),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_cmd),
        .empty (q_empty)
    );

    // mix, drive and failsafe
    ddm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (q_cmd),
        .cmd_valid (!q_empty),
        .cmd_pop   (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty           = !res_valid;
    assign left_duty       = res.left_duty;
    assign left_in_a       = res.left_dir[0];
    assign left_in_b       = res.left_dir[1];
    assign right_duty      = res.right_duty;
    assign right_in_a      = res.right_dir[0];
    assign right_in_b      = res.right_dir[1];
    assign led_on          = res.led_on;
    assign failsafe_active = res.failsafe;

endmodule
